FILE: src/plt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and codes for the positional list table.
// ----------------------------------------------------------------------------
package plt_pkg;

   // Request kinds as they arrive on the request channel.
   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_GET    = 2'd2,
      KIND_LOCATE = 2'd3
   } kind_type;

   // Sequencer states of the table controller.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_GET,
      ST_SCAN,
      ST_RESP
   } state_type;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned POS_W  = 5;

endpackage : plt_pkg
`default_nettype wire

FILE: src/plt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_req_if / plt_rsp_if
// Valid/ready channels carrying request and response beats of the table.
// ----------------------------------------------------------------------------
interface plt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [4:0]         position;
   logic signed [31:0] value;

   modport source (output valid, output kind, output position, output value, input ready);
   modport sink   (input valid, input kind, input position, input value, output ready);
endinterface : plt_req_if

interface plt_rsp_if;
   logic               valid;
   logic               ready;
   logic               status_ok;
   logic signed [31:0] read_value;
   logic [4:0]         found_position;
   logic [4:0]         entry_count;
   logic               is_empty;

   modport source (output valid, output status_ok, output read_value,
                   output found_position, output entry_count, output is_empty,
                   input ready);
   modport sink   (input valid, input status_ok, input read_value,
                   input found_position, input entry_count, input is_empty,
                   output ready);
endinterface : plt_rsp_if
`default_nettype wire

FILE: src/positional_list_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_table
// Ordered list of signed 32-bit words held in one synchronous memory.
//
// Each request beat on req_chan carries a kind (clear, insert, get, locate),
// a 1-based position and a word. Every request produces exactly one response
// beat on rsp_chan with status, the word read, the position found, the entry
// count after the request and an empty flag.
//
// The block handles one request at a time: req_chan.ready is high only while
// the controller is idle, so the next request is taken the cycle after the
// response beat leaves. The memory, with one entry moved or compared per
// cycle, sets the pace of a walk. Clear and a rejected insert or get answer
// straight from idle and a good get reads its entry first. An insert moves each
// entry at or above the position one slot up, top first, then writes the word;
// a locate compares entries in order until a hit or the end of the list.
//
// A synchronous reset empties the list and drops any pending response; the
// memory is not cleared, since no entry is read before it is written. When the
// receiver holds rsp_chan.ready low the response beat stays on the port
// unchanged and no new request is taken.
// ----------------------------------------------------------------------------
module positional_list_table #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   plt_req_if.sink   req_chan,
   plt_rsp_if.source rsp_chan
);
   import plt_pkg::*;

   // Count width holds CAPACITY itself; address width indexes the memory.
   localparam int unsigned CW   = $clog2(CAPACITY + 1);
   localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // Comparison width covers the count, the 5-bit position and one carry.
   localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   // Controller state.
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] pend_addr_ff, pend_addr_in;

   // Request held for the duration of its walk.
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic signed [WORD_W-1:0] val_ff, val_in;

   // Response registers.
   logic                     ok_ff, ok_in;
   logic signed [WORD_W-1:0] rd_ff, rd_in;
   logic [POS_W-1:0]         found_ff, found_in;

   // Entry memory.
   logic [WORD_W-1:0] mem [CAPACITY];
   logic              mem_re, mem_we;
   logic [AW-1:0]     mem_raddr, mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] mem_rdata_ff;

   // Request decode against the current count.
   logic            accept;
   kind_type        req_kind;
   logic [CMPW-1:0] req_pos_ext, count_ext, req_pos_m1;
   logic            insert_ok, get_ok;

   // Walk conditions.
   logic [CMPW-1:0] cur_ext, pos_ff_ext, found_ext;
   logic            shift_more, scan_more, scan_hit;

   assign accept      = req_chan.valid && req_chan.ready;
   assign req_kind    = kind_type'(req_chan.kind);
   assign req_pos_ext = CMPW'(req_chan.position);
   assign count_ext   = CMPW'(count_ff);
   assign req_pos_m1  = req_pos_ext - CMPW'(1);

   // Insert needs a free slot and a position in 1..count+1; get needs 1..count.
   assign insert_ok = (count_ext < CMPW'(CAPACITY)) && (req_pos_ext != '0) &&
                      (req_pos_ext <= count_ext + CMPW'(1));
   assign get_ok    = (req_pos_ext != '0) && (req_pos_ext <= count_ext);

   assign cur_ext    = CMPW'(cur_ff);
   assign pos_ff_ext = CMPW'(pos_ff);
   // The shift still has entries to move while the write target is above the
   // insertion index (1-based position equals 0-based index + 1).
   assign shift_more = (cur_ext >= pos_ff_ext);
   assign scan_more  = (cur_ff < count_ff);
   assign scan_hit   = pend_ff && (mem_rdata_ff == val_ff);
   assign found_ext  = CMPW'(pend_addr_ff) + CMPW'(1);

   // ------------------------------------------------------------------------
   // Next-state logic.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_CLEAR:  state_in = ST_RESP;
                  KIND_INSERT: state_in = insert_ok ? ST_SHIFT : ST_RESP;
                  KIND_GET:    state_in = get_ok ? ST_GET : ST_RESP;
                  KIND_LOCATE: state_in = ST_SCAN;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_SHIFT: begin
            if (!pend_ff && !shift_more) begin
               state_in = ST_RESP;
            end
         end
         ST_GET: begin
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (scan_hit || !scan_more) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath and memory control.
   // ------------------------------------------------------------------------
   always_comb begin
      count_in     = count_ff;
      cur_in       = cur_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      ok_in        = ok_ff;
      rd_in        = rd_ff;
      found_in     = found_ff;
      mem_re       = 1'b0;
      mem_raddr    = req_pos_m1[AW-1:0];
      mem_we       = 1'b0;
      mem_waddr    = cur_ff[AW-1:0];
      mem_wdata    = val_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in   = req_chan.position;
               val_in   = req_chan.value;
               ok_in    = 1'b0;
               rd_in    = '0;
               found_in = '0;
               pend_in  = 1'b0;
               unique case (req_kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                  end
                  KIND_INSERT: begin
                     // First move writes the slot just above the top entry.
                     cur_in = count_ff;
                  end
                  KIND_GET: begin
                     mem_re = get_ok;
                  end
                  KIND_LOCATE: begin
                     cur_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SHIFT: begin
            // Read the entry below the write target; it is written one slot
            // up in the next cycle, overlapped with the following read.
            if (shift_more) begin
               mem_re       = 1'b1;
               mem_raddr    = cur_ff[AW-1:0] - AW'(1);
               cur_in       = cur_ff - CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = cur_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff[AW-1:0];
               mem_wdata = mem_rdata_ff;
            end else if (!shift_more) begin
               // Gap is open at the insertion index: drop the new word in.
               mem_we    = 1'b1;
               mem_waddr = cur_ff[AW-1:0];
               mem_wdata = val_ff;
               count_in  = count_ff + CW'(1);
               ok_in     = 1'b1;
            end
         end
         ST_GET: begin
            rd_in = mem_rdata_ff;
            ok_in = 1'b1;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               ok_in    = 1'b1;
               found_in = found_ext[POS_W-1:0];
            end else if (scan_more) begin
               mem_re       = 1'b1;
               mem_raddr    = cur_ff[AW-1:0];
               cur_in       = cur_ff + CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = cur_ff;
            end
         end
         ST_RESP: ;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      pend_addr_ff <= pend_addr_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      ok_ff        <= ok_in;
      rd_ff        <= rd_in;
      found_ff     <= found_in;
   end

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   // ------------------------------------------------------------------------
   // Channel outputs.
   // ------------------------------------------------------------------------
   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = (state_ff == ST_RESP);
   assign rsp_chan.status_ok      = ok_ff;
   assign rsp_chan.read_value     = rd_ff;
   assign rsp_chan.found_position = found_ff;
   assign rsp_chan.entry_count    = count_ext[POS_W-1:0];
   assign rsp_chan.is_empty       = (count_ff == '0);

endmodule : positional_list_table
`default_nettype wire

FILE: src/plt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks of the positional list table, bound to its top level.
// ----------------------------------------------------------------------------
module plt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_status_ok,
   input wire logic [31:0] rsp_read_value,
   input wire logic [4:0]  rsp_found_position,
   input wire logic [4:0]  rsp_entry_count,
   input wire logic        rsp_is_empty
);

   // No response beat is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status_ok) &&
      $stable(rsp_read_value) && $stable(rsp_found_position) &&
      $stable(rsp_entry_count) && $stable(rsp_is_empty))
      else $error("stalled response changed");

   // The empty flag agrees with the reported count.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_entry_count == 5'd0)
      else $error("empty flag with nonzero count");

   // A failed request reports neither a word nor a position.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status_ok |-> rsp_read_value == 32'd0 &&
      rsp_found_position == 5'd0)
      else $error("failed response carries data");

   // The block takes one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule : plt_checker

bind positional_list_table plt_checker u_plt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_status_ok      (rsp_chan.status_ok),
   .rsp_read_value     (rsp_chan.read_value),
   .rsp_found_position (rsp_chan.found_position),
   .rsp_entry_count    (rsp_chan.entry_count),
   .rsp_is_empty       (rsp_chan.is_empty)
);
`default_nettype wire
